// ===== design/dpb_pkg.sv =====
// shared constants, types and divider step function for depth pixel back-projection
package dpb_pkg;

    // field widths
    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 4;
    localparam int CFG_W      = 16;
    localparam int DEPTH_W    = 16;
    localparam int COORD_W    = 32;

    // depth codes with special meaning
    localparam logic [DEPTH_W-1:0] DEPTH_NONE    = '0;
    localparam logic [DEPTH_W-1:0] DEPTH_INVALID = '1;

    // datapath widths
    localparam int PQ_W       = PIXEL_BITS + FRAC_BITS;
    localparam int OFS_W      = (PQ_W > CFG_W) ? PQ_W : CFG_W;
    localparam int PROD_W     = OFS_W + DEPTH_W;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUO_W      = DIV_STAGES * DIV_STEPS;

    // stream packing
    localparam int IN_W        = 2 * PIXEL_BITS + DEPTH_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * COORD_W + DEPTH_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } dpb_reg_t;

    // camera intrinsics as held in the register file
    typedef struct packed {
        logic [CFG_W-1:0] focal_x;
        logic [CFG_W-1:0] focal_y;
        logic [CFG_W-1:0] center_x;
        logic [CFG_W-1:0] center_y;
    } dpb_cfg_t;

    // per-item flags and depth riding along the pipeline
    typedef struct packed {
        logic               ok;
        logic               neg_x;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
    } dpb_side_t;

    // restoring divider state: partial remainder plus numerator/quotient shift word
    typedef struct packed {
        logic [CFG_W-1:0] rem;
        logic [QUO_W-1:0] work;
    } dpb_div_t;

    // a few restoring divide steps on one axis
    function automatic dpb_div_t div_steps(input dpb_div_t a, input logic [CFG_W-1:0] d);
        dpb_div_t       r;
        logic [CFG_W:0] trial;
        r = a;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial  = {r.rem, r.work[QUO_W-1]};
            r.work = {r.work[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
                trial     = trial - {1'b0, d};
                r.work[0] = 1'b1;
            end
            r.rem = trial[CFG_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/depth_pixel_backprojection_top.sv =====
// top level of the pinhole depth pixel back-projection block
//
// Input stream: one depth pixel per item on s_tdata (column, row, depth in mm).
// Output stream: one camera-frame point per item on m_tdata (x and y in signed
// Q.4 mm, z in mm), with m_tuser high when the point is valid. Depth 0 or
// 65535, or a zero focal length, gives an all-zero point with m_tuser low.
// Intrinsics are loaded through cfg_wr_en / cfg_addr / cfg_wdata
// (0 focal_x, 1 focal_y, 2 center_x, 3 center_y, unsigned Q12.4) and must only
// change while no item is in flight.
// Throughput is one item per clock while m_tready is high. The pipeline has
// twelve register stages (offset, multiply, nine divider stages of four
// quotient bits each, and the output register), the first loaded at the
// accept edge. The divider chain is what sets the depth.
// Reset (aresetn low, synchronous) empties the pipeline and clears the
// intrinsics to zero. When m_tready is low the pipeline keeps accepting until
// every stage holds an item, then s_tready drops; nothing is lost or repeated.
module depth_pixel_backprojection_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [dpb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [dpb_pkg::CFG_W-1:0]           cfg_wdata,
    // input pixels
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel_col, pixel_row, depth
    input  logic [dpb_pkg::IN_TDATA_W-1:0]      s_tdata,
    // output points
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // world_x, world_y, world_z
    output logic [dpb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // valid_res
    output logic                                m_tuser
);

    localparam int NS = dpb_pkg::DIV_STAGES;

    dpb_pkg::dpb_cfg_t  cfg_reg;

    logic               stg_valid [NS+1];
    logic               stg_ready [NS+1];
    dpb_pkg::dpb_side_t stg_side  [NS+1];
    dpb_pkg::dpb_div_t  stg_x     [NS+1];
    dpb_pkg::dpb_div_t  stg_y     [NS+1];

    // intrinsics register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (dpb_pkg::dpb_reg_t'(cfg_addr))
                dpb_pkg::REG_FOCAL_X:  cfg_reg.focal_x  <= cfg_wdata;
                dpb_pkg::REG_FOCAL_Y:  cfg_reg.focal_y  <= cfg_wdata;
                dpb_pkg::REG_CENTER_X: cfg_reg.center_x <= cfg_wdata;
                dpb_pkg::REG_CENTER_Y: cfg_reg.center_y <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // offset and multiply
    dpb_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_col    (s_tdata[0 +: dpb_pkg::PIXEL_BITS]),
        .in_row    (s_tdata[dpb_pkg::PIXEL_BITS +: dpb_pkg::PIXEL_BITS]),
        .in_depth  (s_tdata[2*dpb_pkg::PIXEL_BITS +: dpb_pkg::DEPTH_W]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_side  (stg_side[0]),
        .out_x     (stg_x[0]),
        .out_y     (stg_y[0])
    );

    // divider chain
    for (genvar g = 0; g < NS; g++) begin : g_div
        dpb_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .focal_x   (cfg_reg.focal_x),
            .focal_y   (cfg_reg.focal_y),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_side   (stg_side[g]),
            .in_x      (stg_x[g]),
            .in_y      (stg_y[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_side  (stg_side[g+1]),
            .out_x     (stg_x[g+1]),
            .out_y     (stg_y[g+1])
        );
    end

    // saturation and output register
    dpb_post u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_valid[NS]),
        .in_ready (stg_ready[NS]),
        .in_side  (stg_side[NS]),
        .in_x     (stg_x[NS]),
        .in_y     (stg_y[NS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // input back-pressure only comes from a blocked output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output is free");

endmodule

// ===== design/dpb_prep.sv =====
// front stages: offset from principal point, validity check, offset times depth
module dpb_prep (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dpb_pkg::dpb_cfg_t              cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dpb_pkg::PIXEL_BITS-1:0] in_col,
    input  logic [dpb_pkg::PIXEL_BITS-1:0] in_row,
    input  logic [dpb_pkg::DEPTH_W-1:0]    in_depth,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dpb_pkg::dpb_side_t             out_side,
    output dpb_pkg::dpb_div_t              out_x,
    output dpb_pkg::dpb_div_t              out_y
);

    logic                          ofs_valid_reg;
    dpb_pkg::dpb_side_t            ofs_side_reg;
    dpb_pkg::dpb_side_t            ofs_side_next;
    logic [dpb_pkg::OFS_W-1:0]     mag_x_reg;
    logic [dpb_pkg::OFS_W-1:0]     mag_x_next;
    logic [dpb_pkg::OFS_W-1:0]     mag_y_reg;
    logic [dpb_pkg::OFS_W-1:0]     mag_y_next;
    logic                          ofs_ready;

    logic                          mul_valid_reg;
    dpb_pkg::dpb_side_t            mul_side_reg;
    dpb_pkg::dpb_div_t             mul_x_reg;
    dpb_pkg::dpb_div_t             mul_x_next;
    dpb_pkg::dpb_div_t             mul_y_reg;
    dpb_pkg::dpb_div_t             mul_y_next;

    logic [dpb_pkg::OFS_W-1:0]     pq_x;
    logic [dpb_pkg::OFS_W-1:0]     pq_y;
    logic [dpb_pkg::OFS_W-1:0]     cx;
    logic [dpb_pkg::OFS_W-1:0]     cy;
    logic [dpb_pkg::PROD_W-1:0]    prod_x;
    logic [dpb_pkg::PROD_W-1:0]    prod_y;

    // handshake: a stage takes an item when empty or draining
    assign ofs_ready = !mul_valid_reg || out_ready;
    assign in_ready  = !ofs_valid_reg || ofs_ready;

    // offset from the principal point as sign and magnitude
    always_comb begin
        pq_x = dpb_pkg::OFS_W'(in_col) << dpb_pkg::FRAC_BITS;
        pq_y = dpb_pkg::OFS_W'(in_row) << dpb_pkg::FRAC_BITS;
        cx   = dpb_pkg::OFS_W'(cfg.center_x);
        cy   = dpb_pkg::OFS_W'(cfg.center_y);
        ofs_side_next.neg_x = pq_x < cx;
        ofs_side_next.neg_y = pq_y < cy;
        mag_x_next = ofs_side_next.neg_x ? (cx - pq_x) : (pq_x - cx);
        mag_y_next = ofs_side_next.neg_y ? (cy - pq_y) : (pq_y - cy);
        ofs_side_next.depth = in_depth;
        ofs_side_next.ok    = (in_depth != dpb_pkg::DEPTH_NONE) &&
                              (in_depth != dpb_pkg::DEPTH_INVALID) &&
                              (cfg.focal_x != '0) && (cfg.focal_y != '0);
    end

    // scaled numerator for the divider
    always_comb begin
        prod_x = mag_x_reg * dpb_pkg::PROD_W'(ofs_side_reg.depth);
        prod_y = mag_y_reg * dpb_pkg::PROD_W'(ofs_side_reg.depth);
        mul_x_next.rem  = '0;
        mul_x_next.work = dpb_pkg::QUO_W'(prod_x) << dpb_pkg::FRAC_BITS;
        mul_y_next.rem  = '0;
        mul_y_next.work = dpb_pkg::QUO_W'(prod_y) << dpb_pkg::FRAC_BITS;
    end

    // offset stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_valid_reg <= 1'b0;
        end else if (in_ready) begin
            ofs_valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            ofs_side_reg <= ofs_side_next;
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (ofs_ready) begin
            mul_valid_reg <= ofs_valid_reg;
        end
        if (ofs_valid_reg && ofs_ready) begin
            mul_side_reg <= ofs_side_reg;
            mul_x_reg    <= mul_x_next;
            mul_y_reg    <= mul_y_next;
        end
    end

    assign out_valid = mul_valid_reg;
    assign out_side  = mul_side_reg;
    assign out_x     = mul_x_reg;
    assign out_y     = mul_y_reg;

endmodule

// ===== design/dpb_div_stage.sv =====
// one stage of the pipelined restoring divider, both axes side by side
module dpb_div_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [dpb_pkg::CFG_W-1:0]   focal_x,
    input  logic [dpb_pkg::CFG_W-1:0]   focal_y,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dpb_pkg::dpb_side_t          in_side,
    input  dpb_pkg::dpb_div_t           in_x,
    input  dpb_pkg::dpb_div_t           in_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dpb_pkg::dpb_side_t          out_side,
    output dpb_pkg::dpb_div_t           out_x,
    output dpb_pkg::dpb_div_t           out_y
);

    logic               valid_reg;
    dpb_pkg::dpb_side_t side_reg;
    dpb_pkg::dpb_div_t  x_reg;
    dpb_pkg::dpb_div_t  x_next;
    dpb_pkg::dpb_div_t  y_reg;
    dpb_pkg::dpb_div_t  y_next;

    assign in_ready = !valid_reg || out_ready;

    // quotient bits for this stage
    always_comb begin
        x_next = dpb_pkg::div_steps(in_x, focal_x);
        y_next = dpb_pkg::div_steps(in_y, focal_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            side_reg <= in_side;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

    // a held item keeps its partial quotient until it moves on
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(x_reg) && $stable(y_reg)
                                    && $stable(side_reg))
        else $error("divider stage changed while stalled");

endmodule

// ===== design/dpb_post.sv =====
// sign, saturation, invalid masking and the output register
module dpb_post (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dpb_pkg::dpb_side_t                  in_side,
    input  dpb_pkg::dpb_div_t                   in_x,
    input  dpb_pkg::dpb_div_t                   in_y,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dpb_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);

    logic                              valid_reg;
    logic [dpb_pkg::OUT_TDATA_W-1:0]   tdata_reg;
    logic [dpb_pkg::OUT_TDATA_W-1:0]   tdata_next;
    logic                              tuser_reg;
    logic [dpb_pkg::COORD_W-1:0]       wx;
    logic [dpb_pkg::COORD_W-1:0]       wy;

    // truncated quotient to saturated two's complement
    function automatic logic [dpb_pkg::COORD_W-1:0] to_coord(
        input logic [dpb_pkg::QUO_W-1:0] q, input logic neg);
        logic big;
        logic [dpb_pkg::COORD_W-1:0] r;
        big = |q[dpb_pkg::QUO_W-1:dpb_pkg::COORD_W-1];
        if (neg) begin
            r = big ? {1'b1, {(dpb_pkg::COORD_W-1){1'b0}}}
                    : dpb_pkg::COORD_W'(0) - q[dpb_pkg::COORD_W-1:0];
        end else begin
            r = big ? {1'b0, {(dpb_pkg::COORD_W-1){1'b1}}} : q[dpb_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    assign in_ready = !valid_reg || m_tready;

    // pack x, y, z; all zero for an invalid pixel
    always_comb begin
        wx = to_coord(in_x.work, in_side.neg_x);
        wy = to_coord(in_y.work, in_side.neg_y);
        tdata_next = '0;
        if (in_side.ok) begin
            tdata_next = dpb_pkg::OUT_TDATA_W'({in_side.depth, wy, wx});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            tdata_reg <= tdata_next;
            tuser_reg <= in_side.ok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    // an invalid point carries no coordinates
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid point with nonzero coordinates");

    // a valid point has a usable depth
    a_valid_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[2*dpb_pkg::COORD_W +: dpb_pkg::DEPTH_W] != dpb_pkg::DEPTH_NONE &&
            m_tdata[2*dpb_pkg::COORD_W +: dpb_pkg::DEPTH_W] != dpb_pkg::DEPTH_INVALID)
        else $error("valid point with unusable depth");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the depth pixel back-projection block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RAND_SETS   = 8;
    localparam int RAND_ITEMS  = 50;

    // one expected camera-frame point, x in the lowest bits and valid on top
    typedef struct packed {
        logic                               valid;
        logic [dpb_pkg::DEPTH_W-1:0]        z;
        logic signed [dpb_pkg::COORD_W-1:0] y;
        logic signed [dpb_pkg::COORD_W-1:0] x;
    } point_t;

    // tracks the intrinsics and the points still owed by the block
    class point_scoreboard;
        logic [dpb_pkg::CFG_W-1:0] focal_x;
        logic [dpb_pkg::CFG_W-1:0] focal_y;
        logic [dpb_pkg::CFG_W-1:0] center_x;
        logic [dpb_pkg::CFG_W-1:0] center_y;
        point_t                    expected_points[$];
        int unsigned               mismatches;

        function new();
            focal_x    = '0;
            focal_y    = '0;
            center_x   = '0;
            center_y   = '0;
            mismatches = 0;
        endfunction

        function void set_reg(dpb_pkg::dpb_reg_t idx, logic [dpb_pkg::CFG_W-1:0] val);
            case (idx)
                dpb_pkg::REG_FOCAL_X:  focal_x  = val;
                dpb_pkg::REG_FOCAL_Y:  focal_y  = val;
                dpb_pkg::REG_CENTER_X: center_x = val;
                dpb_pkg::REG_CENTER_Y: center_y = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // (pix * 2^F - center) * depth * 2^F / focal, truncated toward zero, saturated
        function logic [dpb_pkg::COORD_W-1:0] project_axis(
                logic [dpb_pkg::PIXEL_BITS-1:0] pix,
                logic [dpb_pkg::CFG_W-1:0]      center,
                logic [dpb_pkg::DEPTH_W-1:0]    depth,
                logic [dpb_pkg::CFG_W-1:0]      focal);
            longint unsigned pq;
            longint unsigned mag;
            longint unsigned quo;
            bit              neg;
            pq  = longint'(pix) << dpb_pkg::FRAC_BITS;
            neg = pq < longint'(center);
            mag = neg ? (longint'(center) - pq) : (pq - longint'(center));
            quo = ((mag * longint'(depth)) << dpb_pkg::FRAC_BITS) / longint'(focal);
            if (neg) begin
                if (quo >= 64'h8000_0000) return 32'h8000_0000;
                return 32'(64'd0 - quo);
            end
            if (quo > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return 32'(quo);
        endfunction

        // work out the point for an accepted pixel item
        function void note_pixel(logic [dpb_pkg::IN_TDATA_W-1:0] data);
            logic [dpb_pkg::PIXEL_BITS-1:0] col;
            logic [dpb_pkg::PIXEL_BITS-1:0] row;
            logic [dpb_pkg::DEPTH_W-1:0]    depth;
            point_t                         pt;
            col   = data[0 +: dpb_pkg::PIXEL_BITS];
            row   = data[dpb_pkg::PIXEL_BITS +: dpb_pkg::PIXEL_BITS];
            depth = data[2*dpb_pkg::PIXEL_BITS +: dpb_pkg::DEPTH_W];
            pt    = '0;
            if (depth != dpb_pkg::DEPTH_NONE && depth != dpb_pkg::DEPTH_INVALID
                    && focal_x != '0 && focal_y != '0) begin
                pt.x     = project_axis(col, center_x, depth, focal_x);
                pt.y     = project_axis(row, center_y, depth, focal_y);
                pt.z     = depth;
                pt.valid = 1'b1;
            end
            expected_points.push_back(pt);
        endfunction

        task report_mismatch(string field, logic [dpb_pkg::COORD_W-1:0] got,
                             logic [dpb_pkg::COORD_W-1:0] want);
            $display("%0t: %s got %h expected %h", $time, field, got, want);
            mismatches++;
        endtask

        // compare an accepted point with the oldest one owed
        task check_point(logic [dpb_pkg::OUT_TDATA_W-1:0] data, logic user);
            point_t want;
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected item", data[0 +: dpb_pkg::COORD_W], '0);
                return;
            end
            want = expected_points.pop_front();
            if (data[0 +: dpb_pkg::COORD_W] !== want.x)
                report_mismatch("world_x", data[0 +: dpb_pkg::COORD_W], want.x);
            if (data[dpb_pkg::COORD_W +: dpb_pkg::COORD_W] !== want.y)
                report_mismatch("world_y", data[dpb_pkg::COORD_W +: dpb_pkg::COORD_W],
                                want.y);
            if (data[2*dpb_pkg::COORD_W +: dpb_pkg::DEPTH_W] !== want.z)
                report_mismatch("world_z",
                                32'(data[2*dpb_pkg::COORD_W +: dpb_pkg::DEPTH_W]),
                                32'(want.z));
            if (user !== want.valid)
                report_mismatch("valid_res", 32'(user), 32'(want.valid));
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_wr_en;
    logic [dpb_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [dpb_pkg::CFG_W-1:0]          cfg_wdata;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [dpb_pkg::IN_TDATA_W-1:0]     s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [dpb_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               m_tuser;

    point_scoreboard sb;
    int              send_idle;
    int              recv_stall;
    int              idle_cycles = 0;

    depth_pixel_backprojection_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // item monitors on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready) sb.check_point(m_tdata, m_tuser);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // load all four intrinsics, write enable held high across them
    task automatic load_intrinsics(logic [dpb_pkg::CFG_W-1:0] fx,
                                   logic [dpb_pkg::CFG_W-1:0] fy,
                                   logic [dpb_pkg::CFG_W-1:0] cx,
                                   logic [dpb_pkg::CFG_W-1:0] cy);
        logic [dpb_pkg::CFG_W-1:0] vals[4];
        dpb_pkg::dpb_reg_t         idx;
        vals = '{fx, fy, cx, cy};
        idx  = dpb_pkg::REG_FOCAL_X;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(idx, vals[i]);
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
    endtask

    // offer one pixel item, with random idle cycles ahead of it
    task automatic send_pixel(logic [dpb_pkg::PIXEL_BITS-1:0] col,
                              logic [dpb_pkg::PIXEL_BITS-1:0] row,
                              logic [dpb_pkg::DEPTH_W-1:0] depth);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dpb_pkg::IN_TDATA_W'({depth, row, col});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop offering and wait until every owed point has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // register value biased toward the extremes
    function automatic logic [dpb_pkg::CFG_W-1:0] pick_reg(bit is_focal);
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return is_focal ? 16'h0001 : 16'h0000;
        if (k == 1) return 16'hFFFF;
        if (k == 2 && is_focal) return 16'h0000;
        if (k < 9 && is_focal) return dpb_pkg::CFG_W'($urandom_range(16'h0800, 16'h8000));
        return dpb_pkg::CFG_W'($urandom);
    endfunction

    function automatic logic [dpb_pkg::PIXEL_BITS-1:0] pick_pixel();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return dpb_pkg::PIXEL_BITS'($urandom);
    endfunction

    function automatic logic [dpb_pkg::DEPTH_W-1:0] pick_depth();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return dpb_pkg::DEPTH_NONE;
        if (k == 1) return dpb_pkg::DEPTH_INVALID;
        if (k == 2) return 16'd1;
        if (k == 3) return 16'hFFFE;
        return dpb_pkg::DEPTH_W'($urandom_range(1, 16'hFFFE));
    endfunction

    // stimulus
    initial begin
        sb          = new();
        send_idle   = 0;
        recv_stall  = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= dpb_pkg::REG_FOCAL_X;
        cfg_wdata   <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // intrinsics still at reset: every point invalid
        send_pixel(12'd100, 12'd200, 16'd1000);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFE);
        drain();

        // typical camera, depth and position extremes
        load_intrinsics(16'h2000, 16'h1E00, 16'h1400, 16'h0F00);
        send_pixel(12'd0, 12'd0, 16'd1000);
        send_pixel(12'hFFF, 12'hFFF, 16'd1000);
        send_pixel(12'd320, 12'd240, 16'd1000);
        send_pixel(12'd0, 12'd0, dpb_pkg::DEPTH_NONE);
        send_pixel(12'd100, 12'd100, dpb_pkg::DEPTH_INVALID);
        send_pixel(12'hFFF, 12'd0, 16'hFFFE);
        send_pixel(12'd0, 12'hFFF, 16'd1);
        send_pixel(12'd321, 12'd239, 16'd2000);
        send_pixel(12'hAAA, 12'h555, 16'h5A5A);
        send_pixel(12'h555, 12'hAAA, 16'hA5A5);
        drain();

        // tiny focal lengths: positive and negative saturation
        load_intrinsics(16'h0001, 16'h0001, 16'h0000, 16'hFFFF);
        send_pixel(12'hFFF, 12'd0, 16'hFFFE);
        send_pixel(12'd0, 12'hFFF, 16'hFFFE);
        send_pixel(12'hFFF, 12'hFFF, 16'd1);
        drain();

        // one focal length missing
        load_intrinsics(16'hFFFF, 16'h0000, 16'h1000, 16'h1000);
        send_pixel(12'd50, 12'd60, 16'd3000);
        send_pixel(12'hFFF, 12'd0, 16'hFFFE);
        drain();
        load_intrinsics(16'h0000, 16'hFFFF, 16'h1000, 16'h1000);
        send_pixel(12'd50, 12'd60, 16'd3000);
        send_pixel(12'd0, 12'hFFF, 16'd1);
        drain();

        // largest focal lengths, center at opposite corners
        load_intrinsics(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(12'd0, 12'hFFF, 16'hFFFE);
        send_pixel(12'hFFF, 12'd0, 16'd1);
        drain();

        // random intrinsics, cycling through the idling modes
        for (int set = 0; set < RAND_SETS; set++) begin
            case (set % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            load_intrinsics(pick_reg(1'b1), pick_reg(1'b1), pick_reg(1'b0), pick_reg(1'b0));
            for (int n = 0; n < RAND_ITEMS; n++)
                send_pixel(pick_pixel(), pick_pixel(), pick_depth());
            drain();
        end

        send_idle  = 0;
        recv_stall = 0;
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
